/* rtl/lz78_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz78_pkg
// Shared constants and types of the LZ78 encoder with bit packer.
// ----------------------------------------------------------------------------
package lz78_pkg;

	localparam int DICT_ENTRIES_DEF = 4096;
	localparam int INDEX_BITS_DEF   = 12;

	// Widest code that the packer will ever send.
	localparam int MAX_WIDTH = 15;
	// Width of dictionary index arithmetic (start index plus entry count).
	localparam int IDX_W     = 18;
	// Width of the doubling marker that decides code growth.
	localparam int MARK_W    = 15;
	// Width of the text number stamped into every hash slot.
	localparam int EPOCH_W   = 8;
	localparam int START_W   = 12;

	typedef enum logic [1:0] {
		KIND_RAW    = 2'd0,
		KIND_PACKED = 2'd1,
		KIND_PART   = 2'd2,
		KIND_COUNT  = 2'd3
	} kind_t;

endpackage

/* rtl/lz78_encoder_bit_packer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz78_encoder_bit_packer
// LZ78 phrase parser on a hashed child table, with a growing-width packer.
// ----------------------------------------------------------------------------
// Usage:
//   Text bytes enter on in_valid/in_ready with data_byte and last. Bytes of the
//   compressed stream leave on out_valid/out_ready, one item per byte, tagged
//   with byte_kind, the running total_bits, dict_full and end_of_run (set on
//   the last item that an input item causes). cfg_we/cfg_wdata load the start
//   index at any idle time; it takes effect at the start of the next text.
//   Child lookup is an open-addressed hash in one RAM of 2^(INDEX_BITS+1)
//   slots, each slot stamped with a text number so that a new text starts
//   with an empty table. Each probe reads the slot, then compares it; a
//   byte after the first of a text needs one probe plus one per collision.
//   A byte that ends a phrase then shifts code_width+8 bits (code_width
//   alone for a phrase left open at the end of the text) into the packer
//   at one bit per cycle unless an output stall holds it, and the last byte
//   adds up to two flush items. A new item is taken only when the previous
//   one is finished. After reset, and after every 255 texts when the text
//   number wraps, the block clears all 2^(INDEX_BITS+1) slots (8192 by default)
//   with in_ready low. A stalled receiver only holds the packer: the block
//   keeps one result in an output register and one more in a hold register.
// ----------------------------------------------------------------------------
module lz78_encoder_bit_packer
	import lz78_pkg::*;
#(
	parameter int DICT_ENTRIES = DICT_ENTRIES_DEF,
	parameter int INDEX_BITS   = INDEX_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [START_W-1:0]   cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic [1:0]           byte_kind,
	output logic [31:0]          total_bits,
	output logic                 dict_full,
	output logic                 end_of_run
);

	localparam int NW    = INDEX_BITS + 1;
	localparam int HB    = INDEX_BITS + 1;
	localparam int SLOTS = 2 ** HB;
	localparam int EW    = EPOCH_W + NW + 8 + NW;
	localparam int SH_W  = MAX_WIDTH + 8;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_RD, ST_CMP, ST_SHIFT, ST_FLUSH, ST_FLUSH3, ST_DONE
	} state_t;

	state_t               state_q;
	logic [HB-1:0]        sweep_q;
	logic [EPOCH_W-1:0]   epoch_q;
	logic [START_W-1:0]   sidx_q;
	logic [IDX_W-1:0]     nx_q;
	logic [IDX_W-1:0]     nx0_q;
	logic [NW-1:0]        node_q;
	logic [NW-1:0]        cnt_q;
	logic [3:0]           cw_q;
	logic [MARK_W-1:0]    marker_q;
	logic [7:0]           buf_q;
	logic [2:0]           bc_q;
	logic [31:0]          total_q;
	logic                 first_q;
	logic [7:0]           byte_q;
	logic                 last_q;
	logic [HB-1:0]        probe_q;
	logic [SH_W-1:0]      sh_q;
	logic [4:0]           shn_q;
	logic                 full_q;

	logic                 hold_v_q;
	logic [7:0]           hold_byte_q;
	kind_t                hold_kind_q;
	logic [31:0]          hold_total_q;

	logic                 ov_q;
	logic [7:0]           o_byte_q;
	kind_t                o_kind_q;
	logic [31:0]          o_total_q;
	logic                 o_full_q;
	logic                 o_eor_q;

	logic                 mem_we;
	logic [HB-1:0]        mem_waddr;
	logic [EW-1:0]        mem_wdata;
	logic [EW-1:0]        mem_rdata;

	logic [EPOCH_W-1:0]   rd_ep;
	logic [NW-1:0]        rd_parent;
	logic [7:0]           rd_byte;
	logic [NW-1:0]        rd_child;
	logic                 slot_used;
	logic                 slot_hit;
	logic                 accept;
	logic [HB-1:0]        hash_root;
	logic                 has_room;
	logic [15:0]          code_mask;
	logic [IDX_W-1:0]     code_node;
	logic [IDX_W-1:0]     code_child;
	logic [15:0]          code_node_m;
	logic [15:0]          code_child_m;
	logic                 grow;
	logic [7:0]           next_buf;

	logic                 can_emit;
	logic                 can_move;
	logic                 emit_go;
	logic [7:0]           emit_byte;
	kind_t                emit_kind;
	logic [31:0]          emit_total;
	logic                 rel_go;
	logic                 done_ok;

	lz78_ram #(
		.WIDTH (EW),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (probe_q),
		.rdata (mem_rdata)
	);

	assign rd_child  = mem_rdata[NW-1:0];
	assign rd_byte   = mem_rdata[NW+7:NW];
	assign rd_parent = mem_rdata[2*NW+7:NW+8];
	assign rd_ep     = mem_rdata[EW-1:EW-EPOCH_W];
	assign slot_used = (rd_ep == epoch_q);
	assign slot_hit  = slot_used && (rd_parent == node_q) && (rd_byte == byte_q);

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);

	assign hash_root = HB'({data_byte, 4'b0}) ^ HB'(data_byte);
	assign has_room  = (cnt_q < NW'(DICT_ENTRIES));

	// Entry number n of this text carries index nx0 + n - 1.
	assign code_mask    = (16'd1 << cw_q) - 16'd1;
	assign code_node    = (node_q == '0) ? '0 : (nx0_q + IDX_W'(node_q) - IDX_W'(1));
	assign code_child   = nx0_q + IDX_W'(rd_child) - IDX_W'(1);
	assign code_node_m  = code_node[15:0] & code_mask;
	assign code_child_m = code_child[15:0] & code_mask;
	assign grow = (cw_q < 4'(MAX_WIDTH)) &&
		((nx_q + IDX_W'(1)) > (IDX_W'(marker_q) << 1));
	assign next_buf = {buf_q[6:0], sh_q[0]};

	assign can_emit = !hold_v_q || !ov_q || out_ready;
	assign can_move = !ov_q || out_ready;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = probe_q;
		mem_wdata = {epoch_q, node_q, byte_q, NW'(cnt_q + NW'(1))};
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				mem_we    = accept && !first_q;
				mem_waddr = hash_root;
				mem_wdata = {epoch_q, NW'(0), data_byte, NW'(1)};
			end
			ST_CMP: begin
				mem_we = !slot_used && has_room;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		emit_go    = 1'b0;
		emit_byte  = buf_q;
		emit_kind  = KIND_PACKED;
		emit_total = total_q;
		rel_go     = 1'b0;
		done_ok    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				emit_go    = accept && !first_q;
				emit_byte  = data_byte;
				emit_kind  = KIND_RAW;
				emit_total = total_q + 32'd8;
			end
			ST_SHIFT: begin
				emit_go    = (shn_q != '0) && (bc_q == 3'd7) && can_emit;
				emit_byte  = next_buf;
				emit_kind  = KIND_PACKED;
				emit_total = total_q + 32'd8;
			end
			ST_FLUSH: begin
				emit_go    = (bc_q != '0) && can_emit;
				emit_byte  = buf_q;
				emit_kind  = KIND_PART;
				emit_total = total_q + 32'(bc_q);
			end
			ST_FLUSH3: begin
				emit_go    = can_emit;
				emit_byte  = 8'(bc_q);
				emit_kind  = KIND_COUNT;
				emit_total = total_q;
			end
			ST_DONE: begin
				rel_go  = hold_v_q && can_move;
				done_ok = !hold_v_q || can_move;
			end
			default: begin
				emit_go = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			sweep_q  <= '0;
			epoch_q  <= EPOCH_W'(1);
			sidx_q   <= '0;
			nx_q     <= IDX_W'(1);
			nx0_q    <= IDX_W'(1);
			node_q   <= '0;
			cnt_q    <= '0;
			cw_q     <= 4'd1;
			marker_q <= MARK_W'(1);
			buf_q    <= '0;
			bc_q     <= '0;
			total_q  <= '0;
			first_q  <= 1'b0;
			last_q   <= 1'b0;
			full_q   <= 1'b0;
			shn_q    <= '0;
			hold_v_q <= 1'b0;
			ov_q     <= 1'b0;
			o_eor_q  <= 1'b0;
			o_full_q <= 1'b0;
		end else begin
			if ((emit_go && hold_v_q) || rel_go) begin
				ov_q      <= 1'b1;
				o_byte_q  <= hold_byte_q;
				o_kind_q  <= hold_kind_q;
				o_total_q <= hold_total_q;
				o_full_q  <= full_q;
				o_eor_q   <= rel_go;
			end else if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			if (emit_go) begin
				hold_v_q     <= 1'b1;
				hold_byte_q  <= emit_byte;
				hold_kind_q  <= emit_kind;
				hold_total_q <= emit_total;
			end else if (rel_go) begin
				hold_v_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + HB'(1);
					if (sweep_q == HB'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						byte_q <= data_byte;
						last_q <= last;
						full_q <= 1'b0;
						if (!first_q) begin
							first_q <= 1'b1;
							cnt_q   <= NW'(1);
							nx0_q   <= nx_q;
							nx_q    <= nx_q + IDX_W'(1);
							total_q <= total_q + 32'd8;
							state_q <= last ? ST_FLUSH : ST_DONE;
						end else begin
							probe_q <= HB'(node_q) ^ HB'({data_byte, 4'b0}) ^ HB'(data_byte);
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (slot_hit) begin
						node_q <= rd_child;
						if (last_q) begin
							// Open phrase at end of text: index only, no character.
							sh_q    <= SH_W'(code_child_m);
							shn_q   <= 5'(cw_q);
							full_q  <= (cnt_q >= NW'(DICT_ENTRIES - 1));
							state_q <= ST_SHIFT;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (slot_used) begin
						probe_q <= probe_q + HB'(1);
						state_q <= ST_RD;
					end else begin
						sh_q   <= SH_W'(code_node_m) | (SH_W'(byte_q) << cw_q);
						shn_q  <= 5'(cw_q) + 5'd8;
						full_q <= (cnt_q >= NW'(DICT_ENTRIES - 1));
						node_q <= '0;
						if (has_room) begin
							cnt_q <= cnt_q + NW'(1);
							nx_q  <= nx_q + IDX_W'(1);
							if (grow) begin
								cw_q     <= cw_q + 4'd1;
								marker_q <= marker_q << 1;
							end
						end
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (shn_q == '0) begin
						state_q <= last_q ? ST_FLUSH : ST_DONE;
					end else if (bc_q != 3'd7) begin
						buf_q <= next_buf;
						bc_q  <= bc_q + 3'd1;
						sh_q  <= sh_q >> 1;
						shn_q <= shn_q - 5'd1;
					end else if (emit_go) begin
						buf_q   <= '0;
						bc_q    <= '0;
						total_q <= emit_total;
						sh_q    <= sh_q >> 1;
						shn_q   <= shn_q - 5'd1;
					end
				end
				ST_FLUSH: begin
					if (bc_q == '0) begin
						state_q <= ST_DONE;
					end else if (emit_go) begin
						total_q <= emit_total;
						state_q <= ST_FLUSH3;
					end
				end
				ST_FLUSH3: begin
					if (emit_go) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_ok) begin
						if (last_q) begin
							node_q   <= '0;
							cnt_q    <= '0;
							nx_q     <= IDX_W'(sidx_q) + IDX_W'(1);
							cw_q     <= 4'd1;
							marker_q <= MARK_W'(1);
							buf_q    <= '0;
							bc_q     <= '0;
							total_q  <= '0;
							first_q  <= 1'b0;
							// A wrapped text number would revive stale slots.
							if (epoch_q == '1) begin
								epoch_q <= EPOCH_W'(1);
								sweep_q <= '0;
								state_q <= ST_CLEAR;
							end else begin
								epoch_q <= epoch_q + EPOCH_W'(1);
								state_q <= ST_IDLE;
							end
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_we) begin
				sidx_q <= cfg_wdata;
				if (!first_q && cnt_q == '0 && !accept) begin
					nx_q <= IDX_W'(cfg_wdata) + IDX_W'(1);
				end
			end
		end
	end

	assign out_valid  = ov_q;
	assign out_byte   = o_byte_q;
	assign byte_kind  = o_kind_q;
	assign total_bits = o_total_q;
	assign dict_full  = o_full_q;
	assign end_of_run = o_eor_q;

	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !hold_v_q)
		else $error("result left in hold register at idle");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(DICT_ENTRIES))
		else $error("entry count beyond dictionary size");

	a_cw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cw_q >= 4'd1) && (cw_q <= 4'(MAX_WIDTH)))
		else $error("code width out of range");

	a_count_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && o_kind_q == KIND_COUNT) |-> o_eor_q)
		else $error("bit count byte not marked as last result");

endmodule

/* rtl/lz78_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz78_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lz78_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
